/* design/kes_pkg.sv */
// shared types and constants for the key escape sequence decoder
package kes_pkg;

  // operation codes carried on the input side
  localparam logic [1:0] OP_FEED  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_IDLE  = 2'd3;

  // command codes reported with every result
  localparam logic [3:0] KC_NONE       = 4'd0;
  localparam logic [3:0] KC_RIGHT      = 4'd1;
  localparam logic [3:0] KC_LEFT       = 4'd2;
  localparam logic [3:0] KC_UP         = 4'd3;
  localparam logic [3:0] KC_DOWN       = 4'd4;
  localparam logic [3:0] KC_STEP_LEFT  = 4'd5;
  localparam logic [3:0] KC_ENTER      = 4'd6;
  localparam logic [3:0] KC_STEP_RIGHT = 4'd7;
  localparam logic [3:0] KC_LINE       = 4'd8;
  localparam logic [3:0] KC_QUIT       = 4'd9;

  // key bytes
  localparam logic [7:0] KEY_BS      = 8'd8;
  localparam logic [7:0] KEY_LF      = 8'd10;
  localparam logic [7:0] KEY_CR      = 8'd13;
  localparam logic [7:0] KEY_ESC     = 8'd27;
  localparam logic [7:0] KEY_SPACE   = 8'd32;
  localparam logic [7:0] KEY_DIG_0   = 8'd48;
  localparam logic [7:0] KEY_DIG_1   = 8'd49;
  localparam logic [7:0] KEY_DIG_2   = 8'd50;
  localparam logic [7:0] KEY_DIG_5   = 8'd53;
  localparam logic [7:0] KEY_DIG_9   = 8'd57;
  localparam logic [7:0] KEY_UP_A    = 8'd65;
  localparam logic [7:0] KEY_UP_B    = 8'd66;
  localparam logic [7:0] KEY_UP_C    = 8'd67;
  localparam logic [7:0] KEY_UP_D    = 8'd68;
  localparam logic [7:0] KEY_UP_Z    = 8'd90;
  localparam logic [7:0] KEY_BRACKET = 8'd91;
  localparam logic [7:0] KEY_QUIT    = 8'd96;
  localparam logic [7:0] KEY_LO_A    = 8'd97;
  localparam logic [7:0] KEY_LO_Z    = 8'd122;
  localparam logic [7:0] KEY_TILDE   = 8'd126;
  localparam logic [7:0] KEY_DEL     = 8'd127;

  // parser state codes
  localparam logic [1:0] PS_IDLE    = 2'd0;
  localparam logic [1:0] PS_ESC     = 2'd1;
  localparam logic [1:0] PS_BRACKET = 2'd2;
  localparam logic [1:0] PS_TILDE   = 2'd3;

  // classified work handed from the front end to the back end
  typedef struct packed {
    logic [3:0] cmd;
    logic [5:0] len;
    logic       wr_en;
    logic [7:0] wr_char;
    logic       rd_hit;
    logic [4:0] rd_idx;
  } kes_work_t;

  localparam int WORK_W = $bits(kes_work_t);

endpackage

/* design/kes_front.sv */
// front end: escape sequence parser and line count bookkeeping
module kes_front import kes_pkg::*; #(
  parameter int LINE_MAX = 32,
  parameter int CW       = 6,
  parameter int AW       = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [1:0]      op,
  input  logic [7:0]      key_byte,
  input  logic [4:0]      read_index,
  output kes_work_t       work,
  output logic [AW-1:0]   wr_addr
);

  localparam int LW = (CW > 6) ? CW : 6;
  localparam int MW = (CW > 5) ? CW : 5;

  logic [1:0]    ps_r, ps_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          typable, is_nl, is_bs, do_plain;
  logic [LW-1:0] len_ext;

  assign is_bs   = (key_byte == KEY_BS) || (key_byte == KEY_DEL);
  assign is_nl   = (key_byte == KEY_LF) || (key_byte == KEY_CR);
  assign typable = ((key_byte >= KEY_UP_A) && (key_byte <= KEY_UP_Z)) ||
                   ((key_byte >= KEY_LO_A) && (key_byte <= KEY_LO_Z)) ||
                   ((key_byte >= KEY_DIG_0) && (key_byte <= KEY_DIG_9)) ||
                   (key_byte == KEY_SPACE) || is_bs;

  assign wr_addr = cnt_r[AW-1:0];

  always_comb begin
    ps_nxt       = ps_r;
    cnt_nxt      = cnt_r;
    do_plain     = 1'b0;
    work.cmd     = KC_NONE;
    work.wr_en   = 1'b0;
    work.wr_char = key_byte;
    work.rd_hit  = 1'b0;
    work.rd_idx  = read_index;
    unique case (op)
      OP_FEED: begin
        if (key_byte == KEY_QUIT) begin
          work.cmd = KC_QUIT;
        end else begin
          unique case (ps_r)
            PS_IDLE: begin
              if (key_byte == KEY_ESC) ps_nxt = PS_ESC;
              else do_plain = 1'b1;
            end
            PS_ESC: begin
              if (key_byte == KEY_BRACKET) begin
                ps_nxt = PS_BRACKET;
              end else begin
                ps_nxt   = PS_IDLE;
                do_plain = 1'b1;
              end
            end
            PS_BRACKET: begin
              ps_nxt = PS_IDLE;
              unique case (key_byte)
                KEY_UP_A:  work.cmd = KC_UP;
                KEY_UP_B:  work.cmd = KC_DOWN;
                KEY_UP_C:  work.cmd = KC_RIGHT;
                KEY_UP_D:  work.cmd = KC_LEFT;
                KEY_DIG_1: begin
                  work.cmd = KC_ENTER;
                  ps_nxt   = PS_TILDE;
                end
                KEY_DIG_2: begin
                  work.cmd = KC_STEP_LEFT;
                  ps_nxt   = PS_TILDE;
                end
                KEY_DIG_5: begin
                  work.cmd = KC_STEP_RIGHT;
                  ps_nxt   = PS_TILDE;
                end
                default: do_plain = 1'b1;
              endcase
            end
            PS_TILDE: begin
              ps_nxt = PS_IDLE;
              if (key_byte != KEY_TILDE) do_plain = 1'b1;
            end
            default: ps_nxt = PS_IDLE;
          endcase
          // idle handling of a byte; esc lands here as a dropped byte
          if (do_plain) begin
            if (typable) begin
              if (is_bs) begin
                if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
              end else if (cnt_r < CW'(LINE_MAX)) begin
                work.wr_en = 1'b1;
                cnt_nxt    = cnt_r + CW'(1);
              end
            end else if (is_nl) begin
              work.cmd = KC_LINE;
            end
          end
        end
      end
      OP_CLEAR: cnt_nxt = '0;
      OP_READ: begin
        work.rd_hit = (MW'(read_index) < MW'(cnt_r)) &&
                      (32'(read_index) < 32'(LINE_MAX));
      end
      default: ;
    endcase
    len_ext  = LW'(cnt_nxt);
    work.len = len_ext[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r  <= PS_IDLE;
      cnt_r <= '0;
    end else if (accept) begin
      ps_r  <= ps_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(LINE_MAX))
    else $error("line count above line size");

  a_quit_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (op == OP_FEED) && (key_byte == KEY_QUIT) |=> ps_r == $past(ps_r))
    else $error("quit key changed parser state");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (op == OP_CLEAR) |=> cnt_r == '0)
    else $error("clear left characters in line");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept && work.wr_en |-> (cnt_r < CW'(LINE_MAX)) && (ps_nxt != PS_TILDE))
    else $error("line write beyond line size");

endmodule

/* design/kes_queue.sv */
// two-entry queue between front end and back end
module kes_queue import kes_pkg::*; #(
  parameter int DW = WORK_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] pop_data
);

  logic [DW-1:0] slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty))
    else $error("pop from empty queue");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers out of step with count");

endmodule

/* design/kes_back.sv */
// back end: line memory access and result register
module kes_back import kes_pkg::*; #(
  parameter int LINE_MAX = 32,
  parameter int AW       = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  kes_work_t     work,
  input  logic [AW-1:0] wr_addr,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    out_cmd,
  output logic [5:0]    out_len,
  output logic [7:0]    out_char
);

  localparam int IW = (AW > 5) ? AW : 5;

  logic [7:0]    line_mem [LINE_MAX];
  logic [7:0]    rd_data_r;
  logic          valid_r, valid_nxt;
  logic          hit_r;
  logic [3:0]    cmd_r;
  logic [5:0]    len_r;
  logic [IW-1:0] idx_ext;
  logic [AW-1:0] rd_addr;

  assign idx_ext = IW'(work.rd_idx);
  assign rd_addr = idx_ext[AW-1:0];

  // take the next entry when the result register is empty or draining
  assign pop       = q_valid && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (pop && work.wr_en) line_mem[wr_addr] <= work.wr_char;
    if (pop) rd_data_r <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hit_r <= work.rd_hit;
      cmd_r <= work.cmd;
      len_r <= work.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  assign out_valid = valid_r;
  assign out_cmd   = cmd_r;
  assign out_len   = len_r;
  assign out_char  = hit_r ? rd_data_r : 8'd0;

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(cmd_r) && $stable(len_r))
    else $error("stalled result changed");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |-> !pop)
    else $error("entry taken while result stalled");

  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r)
    else $error("taken entry produced no result");

endmodule

/* design/key_escape_sequence_decoder_top.sv */
// top level of the key escape sequence decoder
//
//  channel  dir  handshake               payload
//  in_      in   in_tvalid / in_tready   tdata: key_byte, read_index; tuser: op
//  out_     out  out_tvalid / out_tready tdata: command, line_length, read_char
//
// one transaction per cycle sustained while results are taken; each goes from input to result
// through parse and count update into the queue, then line memory access into the result register
// a two-entry queue parts the parser from the memory side, so a stalled result
// holds the back end only; the input stalls once the queue is full
// synchronous active-low reset clears parser state, line count and handshakes;
// line memory contents are not cleared and need no clearing pass
module key_escape_sequence_decoder_top import kes_pkg::*; #(
  parameter int LINE_MAX = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] key_byte, [12:8] read_index, [15:13] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [3:0] command, [9:4] line_length, [17:10] read_char
);

  localparam int CW = $clog2(LINE_MAX + 1);
  localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int DW = WORK_W + AW;

  logic          accept, q_full, q_valid, pop;
  kes_work_t     front_work, back_work;
  logic [AW-1:0] front_addr, back_addr;
  logic [DW-1:0] q_out;
  logic [3:0]    res_cmd;
  logic [5:0]    res_len;
  logic [7:0]    res_char;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  kes_front #(.LINE_MAX(LINE_MAX), .CW(CW), .AW(AW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .op         (in_tuser),
    .key_byte   (in_tdata[7:0]),
    .read_index (in_tdata[12:8]),
    .work       (front_work),
    .wr_addr    (front_addr)
  );

  kes_queue #(.DW(DW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data ({front_addr, front_work}),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  assign back_work = kes_work_t'(q_out[WORK_W-1:0]);
  assign back_addr = q_out[DW-1 -: AW];

  kes_back #(.LINE_MAX(LINE_MAX), .AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .work      (back_work),
    .wr_addr   (back_addr),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cmd   (res_cmd),
    .out_len   (res_len),
    .out_char  (res_char)
  );

  assign out_tdata = {6'd0, res_char, res_len, res_cmd};

endmodule

/* test/key_escape_sequence_decoder_checker.sv */
// checker for the key escape sequence decoder: tracks the parser and line, compares every result
`timescale 1ns / 1ps
module key_escape_sequence_decoder_checker import kes_pkg::*; #(
  parameter int LINE_MAX = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          full_drops
);

  typedef struct packed {
    logic [3:0] command;
    logic [5:0] line_length;
    logic [7:0] read_char;
  } key_result_t;

  logic [1:0]  parse_st;
  logic [7:0]  line_mem [LINE_MAX];
  logic [5:0]  line_len;
  key_result_t expected_results [$];
  int          mismatches = 0;
  int          checked = 0;
  int          dropped = 0;

  function automatic bit is_typable(logic [7:0] b);
    return (b >= KEY_UP_A && b <= KEY_UP_Z) || (b >= KEY_LO_A && b <= KEY_LO_Z) ||
           (b >= KEY_DIG_0 && b <= KEY_DIG_9) || b == KEY_SPACE ||
           b == KEY_BS || b == KEY_DEL;
  endfunction

  function automatic void edit_line(logic [7:0] b);
    if (b == KEY_BS || b == KEY_DEL) begin
      if (line_len > 0) line_len = line_len - 6'd1;
    end else if (line_len < LINE_MAX) begin
      line_mem[line_len] = b;
      line_len = line_len + 6'd1;
    end else begin
      dropped++;
    end
  endfunction

  // what the idle state does with a byte other than escape
  function automatic logic [3:0] plain_key(logic [7:0] b);
    if (is_typable(b)) edit_line(b);
    else if (b == KEY_LF || b == KEY_CR) return KC_LINE;
    return KC_NONE;
  endfunction

  function automatic logic [3:0] feed_key(logic [7:0] b);
    // quit leaves the parser where it was
    if (b == KEY_QUIT) return KC_QUIT;
    case (parse_st)
      PS_IDLE: begin
        if (b == KEY_ESC) begin
          parse_st = PS_ESC;
          return KC_NONE;
        end
        return plain_key(b);
      end
      PS_ESC: begin
        if (b == KEY_BRACKET) begin
          parse_st = PS_BRACKET;
          return KC_NONE;
        end
        parse_st = PS_IDLE;
        return plain_key(b);
      end
      PS_BRACKET: begin
        parse_st = PS_IDLE;
        case (b)
          KEY_UP_A:  return KC_UP;
          KEY_UP_B:  return KC_DOWN;
          KEY_UP_C:  return KC_RIGHT;
          KEY_UP_D:  return KC_LEFT;
          KEY_DIG_1: begin parse_st = PS_TILDE; return KC_ENTER; end
          KEY_DIG_2: begin parse_st = PS_TILDE; return KC_STEP_LEFT; end
          KEY_DIG_5: begin parse_st = PS_TILDE; return KC_STEP_RIGHT; end
          default:   return plain_key(b);
        endcase
      end
      default: begin
        parse_st = PS_IDLE;
        if (b == KEY_TILDE) return KC_NONE;
        return plain_key(b);
      end
    endcase
  endfunction

  function automatic key_result_t decode_key_op(logic [1:0] op, logic [7:0] b,
                                                logic [4:0] idx);
    key_result_t r;
    r = '0;
    case (op)
      OP_FEED:  r.command = feed_key(b);
      OP_CLEAR: line_len = '0;
      OP_READ:  if (idx < line_len) r.read_char = line_mem[idx];
      default:  ;
    endcase
    r.line_length = line_len;
    return r;
  endfunction

  always @(posedge clk) begin
    key_result_t got;
    key_result_t want;
    if (!rst_n) begin
      expected_results.delete();
      parse_st = PS_IDLE;
      line_len = '0;
    end else begin
      // results first, so a result never matches an item taken in the same cycle
      if (out_tvalid && out_tready) begin
        got.command     = out_tdata[3:0];
        got.line_length = out_tdata[9:4];
        got.read_char   = out_tdata[17:10];
        checked++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: cmd=%0d len=%0d char=0x%02h",
                     $realtime, got.command, got.line_length, got.read_char);
        end else begin
          want = expected_results.pop_front();
          if (got.command !== want.command || got.line_length !== want.line_length ||
              got.read_char !== want.read_char) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch: expected cmd=%0d len=%0d char=0x%02h,",
                        " got cmd=%0d len=%0d char=0x%02h"}, $realtime,
                       want.command, want.line_length, want.read_char,
                       got.command, got.line_length, got.read_char);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(decode_key_op(in_tuser, in_tdata[7:0], in_tdata[12:8]));
    end
    fail_count   <= mismatches;
    pending      <= expected_results.size();
    results_seen <= checked;
    full_drops   <= dropped;
  end

endmodule

/* test/key_escape_sequence_decoder_top_tb.sv */
// testbench top for the key escape sequence decoder: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module key_escape_sequence_decoder_top_tb import kes_pkg::*; ();

  localparam int LINE_MAX    = 32;
  localparam int TOTAL_ITEMS = 1650;
  localparam int QUIET_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  int fail_count;
  int pending;
  int results_seen;
  int full_drops;
  int sent_count = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  logic [7:0] seq_finals [7] = '{KEY_UP_A, KEY_UP_B, KEY_UP_C, KEY_UP_D,
                                 KEY_DIG_1, KEY_DIG_2, KEY_DIG_5};

  key_escape_sequence_decoder_top #(.LINE_MAX(LINE_MAX)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  key_escape_sequence_decoder_checker #(.LINE_MAX(LINE_MAX)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .full_drops   (full_drops)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk)
    out_tready <= !idle_on || ($urandom_range(0, 99) >= 30);

  // ends the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending);
        $display("key_escape_sequence_decoder_top_tb failed");
        $finish;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_op(input logic [1:0] op, input logic [7:0] key, input logic [4:0] idx);
    while (idle_on && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, idx, key};
    do @(posedge clk); while (!in_tready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic feed(input logic [7:0] key);
    send_op(OP_FEED, key, 5'($urandom_range(0, 31)));
  endtask

  // occasionally slips a quit key in front, which must not disturb the parser
  task automatic feed_in_seq(input logic [7:0] key);
    if ($urandom_range(0, 9) == 0) feed(KEY_QUIT);
    feed(key);
  endtask

  function automatic logic [7:0] random_typable();
    case ($urandom_range(0, 3))
      0:       return KEY_UP_A + 8'($urandom_range(0, 25));
      1:       return KEY_LO_A + 8'($urandom_range(0, 25));
      2:       return KEY_DIG_0 + 8'($urandom_range(0, 9));
      default: return KEY_SPACE;
    endcase
  endfunction

  initial begin
    int pick;
    int n;
    logic [7:0] fin;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_FEED;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty line cases, typing, reads, full escape sequences and broken ones
    send_op(OP_CLEAR, 8'h00, 5'd0);
    feed(KEY_BS);
    feed(KEY_UP_A);
    feed(KEY_LO_Z);
    feed(KEY_DIG_9);
    feed(KEY_SPACE);
    send_op(OP_READ, 8'hff, 5'd3);
    send_op(OP_READ, 8'h00, 5'd31);
    feed(KEY_DEL);
    feed(KEY_ESC);
    feed(KEY_QUIT);
    feed(KEY_BRACKET);
    feed(KEY_UP_D);
    feed(KEY_ESC);
    feed(KEY_BRACKET);
    feed(KEY_DIG_1);
    feed(KEY_TILDE);
    feed(KEY_ESC);
    feed(KEY_ESC);
    feed(KEY_UP_Z);
    feed(KEY_CR);
    feed(KEY_LF);
    feed(8'hff);
    send_op(OP_IDLE, 8'hff, 5'd31);
    feed(8'h00);

    while (sent_count < TOTAL_ITEMS) begin
      // a stretch with no idling on either side
      idle_on = !(sent_count >= 700 && sent_count < 1000);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 8);
        repeat (n) feed(random_typable());
      end else if (pick < 50) begin
        fin = seq_finals[$urandom_range(0, 6)];
        feed_in_seq(KEY_ESC);
        feed_in_seq(KEY_BRACKET);
        feed_in_seq(fin);
        if (fin == KEY_DIG_1 || fin == KEY_DIG_2 || fin == KEY_DIG_5) begin
          if ($urandom_range(0, 3) != 0) feed_in_seq(KEY_TILDE);
          else feed(($urandom_range(0, 1) == 0) ? KEY_ESC : 8'($urandom_range(0, 255)));
        end
      end else if (pick < 58) begin
        feed(KEY_ESC);
        if ($urandom_range(0, 1) == 0) feed(KEY_BRACKET);
        case ($urandom_range(0, 3))
          0:       feed(KEY_ESC);
          1:       feed(random_typable());
          2:       feed(($urandom_range(0, 1) == 0) ? KEY_CR : KEY_LF);
          default: feed(8'($urandom_range(0, 255)));
        endcase
      end else if (pick < 66) begin
        repeat ($urandom_range(1, 4)) feed(($urandom_range(0, 1) == 0) ? KEY_BS : KEY_DEL);
      end else if (pick < 71) begin
        feed(($urandom_range(0, 1) == 0) ? KEY_CR : KEY_LF);
      end else if (pick < 75) begin
        feed(KEY_QUIT);
      end else if (pick < 80) begin
        send_op(OP_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
      end else if (pick < 90) begin
        n = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 31);
        send_op(OP_READ, 8'($urandom_range(0, 255)), 5'(n));
      end else if (pick < 93) begin
        send_op(OP_IDLE, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
      end else begin
        feed(8'($urandom_range(0, 255)));
      end
    end
    in_tvalid <= 1'b0;
    idle_on = 1'b1;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("drove %0d transactions (directed, escape sequences, typing, edits, reads, noise)",
             sent_count);
    $display("checked %0d results, %0d typed characters dropped at a full line",
             results_seen, full_drops);
    if (fail_count == 0 && pending == 0) begin
      $display("key_escape_sequence_decoder_top_tb passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("key_escape_sequence_decoder_top_tb failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/kes_pkg.sv
design/kes_front.sv
design/kes_queue.sv
design/kes_back.sv
design/key_escape_sequence_decoder_top.sv
test/key_escape_sequence_decoder_checker.sv
test/key_escape_sequence_decoder_top_tb.sv
